// ----- rtl/core/lpft_pkg.sv -----
package lpft_pkg;

  // Page number width carried on the request and the eviction report.
  localparam int unsigned PageW = 32;

  // Width of the reported frame number (low bits of the frame).
  localparam int unsigned FrameIdxW = 3;

  // Default number of page frames.
  localparam int unsigned NumFramesDefault = 8;

endpackage

// ----- rtl/core/lru_page_frame_tracker_core.sv -----
// Fully associative page-frame tracker with LRU replacement.
//
// Request channel: in_valid_i / in_stall_o carry one page number (page_id_i)
// per item. Result channel: out_valid_o / out_stall_i carry one result per
// request: hit flag, frame now holding the page, and the evicted page if a
// full miss forced one out. An item moves when valid is high and stall is low.
//
// Timing: a request is captured in an input register; the tag compares, rank
// update and frame choice are then done in one pass and the result lands in
// the output register once that register is free. Throughput is one item
// per cycle while the receiver does not stall.
//
// Reset empties every frame (valid bits and ranks cleared); tags are not
// cleared since they are only looked at behind a valid bit.
// When the receiver stalls, the result register holds its item, the input
// register fills, and in_stall_o then rises; nothing is lost or repeated.
module lru_page_frame_tracker_core #(
  parameter int unsigned NUM_FRAMES = lpft_pkg::NumFramesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lpft_pkg::PageW-1:0]     page_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [lpft_pkg::FrameIdxW-1:0] frame_index_o,
  output logic                           evicted_valid_o,
  output logic [lpft_pkg::PageW-1:0]     evicted_page_o
);
  import lpft_pkg::*;

  localparam int unsigned FrameW = $clog2(NUM_FRAMES);
  localparam int unsigned RankW  = $clog2(NUM_FRAMES);
  localparam logic [RankW-1:0] OldestRank = RankW'(NUM_FRAMES - 1);

  // input register
  logic             in_valid_q;
  logic [PageW-1:0] page_q;

  // frame state
  logic [PageW-1:0] tag_q   [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_q, valid_d;
  logic [RankW-1:0] rank_q  [NUM_FRAMES];
  logic [RankW-1:0] rank_d  [NUM_FRAMES];

  // result register
  logic                 out_valid_q;
  logic                 hit_q;
  logic [FrameIdxW-1:0] frame_q;
  logic                 ev_valid_q;
  logic [PageW-1:0]     ev_page_q;

  logic out_free;
  logic proc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // lookup and replacement choice
  logic [NUM_FRAMES-1:0] hit_vec;
  logic                  hit;
  logic [FrameW-1:0]     hit_idx;
  logic                  free_any;
  logic [FrameW-1:0]     free_idx;
  logic [FrameW-1:0]     victim_idx;
  logic [FrameW-1:0]     fill_idx;
  logic [FrameW-1:0]     res_idx;
  logic                  full_miss;
  logic [RankW-1:0]      hit_rank;

  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == page_q);
      if (hit_vec[i]) begin
        hit_idx = FrameW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = FrameW'(i);
      end
      // ranks form a permutation when full, so the oldest is unique
      if (rank_q[i] == OldestRank) begin
        victim_idx = FrameW'(i);
      end
    end
    hit       = |hit_vec;
    free_any  = !(&valid_q);
    full_miss = !hit && !free_any;
    fill_idx  = free_any ? free_idx : victim_idx;
    res_idx   = hit ? hit_idx : fill_idx;
    hit_rank  = rank_q[hit_idx];
  end

  // recency update
  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
      if (hit) begin
        if (FrameW'(i) == hit_idx) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end else if (FrameW'(i) == fill_idx) begin
        valid_d[i] = 1'b1;
        rank_d[i]  = '0;
      end else if (valid_q[i]) begin
        rank_d[i] = rank_q[i] + 1'b1;
      end
    end
  end

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        valid_q <= valid_d;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  // payload: request page, tags, result fields
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      page_q <= page_id_i;
    end
    if (proc) begin
      if (!hit) begin
        tag_q[fill_idx] <= page_q;
      end
      hit_q      <= hit;
      frame_q    <= FrameIdxW'(res_idx);
      ev_valid_q <= full_miss;
      ev_page_q  <= full_miss ? tag_q[victim_idx] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;

endmodule

// ----- sim/tb_lru_page_frame_tracker_core.sv -----
`timescale 1ns / 1ps

module tb_lru_page_frame_tracker_core;

  import lpft_pkg::*;

  localparam int unsigned NumFrames = NumFramesDefault;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPages = 750;

  // One result item as the block reports it.
  typedef struct packed {
    logic                 hit;
    logic [FrameIdxW-1:0] frame;
    logic                 ev_valid;
    logic [PageW-1:0]     ev_page;
  } page_result_t;

  // Frame-set predictor plus the queue of results still owed by the block.
  class lru_scoreboard;
    logic [PageW-1:0] tag [NumFrames];
    bit               resident [NumFrames];
    int unsigned      age [NumFrames];
    page_result_t     owed [$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < NumFrames; i++) begin
        tag[i]      = '0;
        resident[i] = 1'b0;
        age[i]      = 0;
      end
      mismatches = 0;
    endfunction

    // Apply one accepted page to the frame set and queue its result.
    function void note_page(logic [PageW-1:0] page);
      int           hit_idx;
      int           free_idx;
      int           victim;
      int unsigned  hit_age;
      page_result_t res;
      hit_idx  = -1;
      free_idx = -1;
      victim   = -1;
      res      = '0;

      for (int i = 0; i < NumFrames; i++) begin
        if (resident[i] && tag[i] == page && hit_idx < 0) hit_idx = i;
      end

      if (hit_idx >= 0) begin
        // Touch: only frames younger than the hit one get older.
        hit_age = age[hit_idx];
        for (int i = 0; i < NumFrames; i++) begin
          if (resident[i] && age[i] < hit_age) age[i]++;
        end
        age[hit_idx] = 0;
        res.hit   = 1'b1;
        res.frame = FrameIdxW'(hit_idx);
        owed.push_back(res);
        return;
      end

      for (int i = 0; i < NumFrames; i++) begin
        if (!resident[i] && free_idx < 0) free_idx = i;
      end

      if (free_idx < 0) begin
        // Set full: oldest frame goes, lowest index wins a tie.
        for (int i = 0; i < NumFrames; i++) begin
          if (resident[i] && (victim < 0 || age[i] > age[victim])) victim = i;
        end
        res.ev_valid     = 1'b1;
        res.ev_page      = tag[victim];
        resident[victim] = 1'b0;
        free_idx         = victim;
      end

      for (int i = 0; i < NumFrames; i++) begin
        if (resident[i]) age[i]++;
      end
      tag[free_idx]      = page;
      resident[free_idx] = 1'b1;
      age[free_idx]      = 0;
      res.frame = FrameIdxW'(free_idx);
      owed.push_back(res);
    endfunction

    function void check_result(page_result_t got);
      page_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing owed: hit=%0b frame=%0d ev=%0b page=%h",
                   $realtime, got.hit, got.frame, got.ev_valid, got.ev_page);
        return;
      end
      want = owed.pop_front();
      if (got.hit !== want.hit || got.frame !== want.frame ||
          got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp hit=%0b frame=%0d ev=%0b page=%h got %0b %0d %0b %h",
                   $realtime, want.hit, want.frame, want.ev_valid, want.ev_page,
                   got.hit, got.frame, got.ev_valid, got.ev_page);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PageW-1:0]     page_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic [FrameIdxW-1:0] frame_index;
  logic                 ev_valid;
  logic [PageW-1:0]     ev_page;

  lru_scoreboard    sb;
  logic [PageW-1:0] page_plan [$];
  logic [PageW-1:0] working_set [12];
  int unsigned      idle_cycles = 0;
  int unsigned      stall_mode = 0;
  int unsigned      mode_timer = 0;
  int unsigned      stall_phase = 0;

  lru_page_frame_tracker_core #(
    .NUM_FRAMES(NumFrames)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .page_id_i      (page_id),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .frame_index_o  (frame_index),
    .evicted_valid_o(ev_valid),
    .evicted_page_o (ev_page)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one page and hold it until the block takes it.
  task automatic send_page(input logic [PageW-1:0] p);
    in_valid <= 1'b1;
    page_id  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly a 12-page working set: more pages than frames, so hits,
  // fills and evictions all keep happening. A narrow slice of the set
  // gives runs of hits at every rank; the rest is fresh noise.
  function automatic logic [PageW-1:0] pick_page();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return working_set[$urandom_range(0, 11)];
    if (roll < 80) return working_set[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Input and output monitor, receiver stall pattern and watchdog.
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      sb.note_page(page_id);
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(page_result_t'{hit, frame_index, ev_valid, ev_page});
      moved = 1'b1;
    end

    // Receiver: a new random stall mode whenever the mode timer runs out.
    if (mode_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_timer = $urandom_range(40, 80);
    end else begin
      mode_timer--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= (stall_phase % 5 != 0);
    endcase

    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    int unsigned gap;
    sb = new();

    // Directed: extreme page values, fill to full, touches at the
    // youngest and oldest rank, then an eviction of the all-ones page.
    page_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000,
                  32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF};

    for (int i = 0; i < 12; i++) working_set[i] = $urandom;
    for (int n = 0; n < RandomPages; n++) begin
      // Slowly drift the working set so old pages age out.
      if (n % 60 == 59) working_set[$urandom_range(0, 11)] = $urandom;
      page_plan.push_back(pick_page());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender: bursts of random length, gaps of random length, often none.
    while (page_plan.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && page_plan.size() != 0) begin
        send_page(page_plan.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lpft_pkg.sv
rtl/core/lru_page_frame_tracker_core.sv
sim/tb_lru_page_frame_tracker_core.sv
